// ----- src/bmhq_pkg.sv -----
// Package for the binary min-heap queue: widths, codes, request/response types.
// No dependencies.
`default_nettype none
package bmhq_pkg;
   localparam int CAPACITY  = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   localparam logic       KIND_PUSH = 1'b0;
   localparam logic       KIND_POP  = 1'b1;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [31:0] popped_key;
      logic [1:0]  status;
      logic [31:0] front_key;
      logic [10:0] count;
   } rsp_type;

   typedef struct packed {
      logic                 kind;
      logic [KEY_WIDTH-1:0] key;
   } cmd_type;
endpackage
`default_nettype wire

// ----- src/bmhq_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- src/bmhq_front.sv -----
// Front end: accepts requests into a two-entry command queue.
// Depends on bmhq_pkg.
`default_nettype none
module bmhq_front import bmhq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_take
);
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       do_push, do_pop;
   cmd_type    cmd_new;

   assign req_full  = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_data  = q_ff[rd_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;
   assign cmd_new   = '{kind: req_data.kind, key: req_data.key[KEY_WIDTH-1:0]};

   always_comb begin
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
      if (do_push) q_ff[wr_ff] <= cmd_new;
   end
endmodule
`default_nettype wire

// ----- src/bmhq_back.sv -----
// Back end: sift-up / sift-down sequencer over the heap RAM, one-entry result register.
// Depends on bmhq_pkg and bmhq_ram.
`default_nettype none
module bmhq_back import bmhq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_take,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_UP    = 8'b00000010,
      S_UPCMP = 8'b00000100,
      S_PLAST = 8'b00001000,
      S_DN    = 8'b00010000,
      S_DNL   = 8'b00100000,
      S_DNR   = 8'b01000000,
      S_RSP   = 8'b10000000
   } state_type;

   state_type            st_ff, st_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, pos_ff, pos_in;
   logic [KEY_WIDTH-1:0] val_ff, val_in, lk_ff, lk_in, pop_ff, pop_in;
   logic [KEY_WIDTH-1:0] root_ff, root_in;
   logic                 rv_ff, rv_in;
   rsp_type              rsp_ff, rsp_in;
   logic [1:0]           stat_ff, stat_in;

   logic                 we;
   logic [ADDR_W-1:0]    wa, ra;
   logic [KEY_WIDTH-1:0] wd, rd, child;
   logic [CNT_W:0]       cnt_x, left, right;
   logic                 has_kids, has_right, right_pick;

   bmhq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   assign rsp_empty  = !rv_ff;
   assign rsp_data   = rsp_ff;
   assign cnt_x      = {1'b0, cnt_ff};
   assign left       = {pos_ff, 1'b0};
   assign right      = left + (CNT_W+1)'(1);
   assign has_kids   = left <= cnt_x;
   assign has_right  = right <= cnt_x;
   // rd holds the right child in S_DNR; equal children take the right one
   assign right_pick = !(lk_ff < rd);
   assign child      = right_pick ? rd : lk_ff;

   // slot n lives at address n-1
   function automatic logic [ADDR_W-1:0] adr(input logic [CNT_W:0] p);
      logic [CNT_W:0] t;
      t = p - 1'b1;
      return t[ADDR_W-1:0];
   endfunction

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; pos_in = pos_ff; val_in = val_ff;
      lk_in = lk_ff; pop_in = pop_ff; stat_in = stat_ff;
      rv_in = rv_ff && !rsp_pop; rsp_in = rsp_ff;
      we = 1'b0; wa = '0; wd = val_ff; ra = '0; cmd_take = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid && !rv_in) begin
               cmd_take = 1'b1;
               pop_in = '0;
               stat_in = ST_OK;
               if (cmd_data.kind == KIND_PUSH) begin
                  if (cnt_ff >= CNT_W'(CAPACITY)) begin
                     stat_in = ST_FULL; st_in = S_RSP;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                     pos_in = cnt_ff + 1'b1;
                     val_in = cmd_data.key;
                     st_in = S_UP;
                  end
               end else if (cnt_ff == '0) begin
                  stat_in = ST_EMPTY; st_in = S_RSP;
               end else begin
                  pop_in = root_ff;
                  cnt_in = cnt_ff - 1'b1;
                  ra = adr(cnt_x);
                  st_in = S_PLAST;
               end
            end
         end
         S_UP: begin
            if (pos_ff == CNT_W'(1)) begin
               we = 1'b1; wa = adr({1'b0, pos_ff}); st_in = S_RSP;
            end else begin
               ra = adr({2'b00, pos_ff[CNT_W-1:1]}); st_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            we = 1'b1; wa = adr({1'b0, pos_ff});
            if (val_ff < rd) begin
               wd = rd; pos_in = pos_ff >> 1; st_in = S_UP;
            end else begin
               st_in = S_RSP;
            end
         end
         S_PLAST: begin
            val_in = rd;
            pos_in = CNT_W'(1);
            st_in = (cnt_ff == '0) ? S_RSP : S_DN;
         end
         S_DN: begin
            if (!has_kids) begin
               we = 1'b1; wa = adr({1'b0, pos_ff}); st_in = S_RSP;
            end else begin
               ra = adr(left); st_in = S_DNL;
            end
         end
         S_DNL: begin
            lk_in = rd;
            if (has_right) begin
               ra = adr(right); st_in = S_DNR;
            end else begin
               we = 1'b1; wa = adr({1'b0, pos_ff});
               if (val_ff > rd) begin
                  wd = rd; pos_in = left[CNT_W-1:0]; st_in = S_DN;
               end else begin
                  st_in = S_RSP;
               end
            end
         end
         S_DNR: begin
            we = 1'b1; wa = adr({1'b0, pos_ff});
            if (val_ff > child) begin
               wd = child;
               pos_in = right_pick ? right[CNT_W-1:0] : left[CNT_W-1:0];
               st_in = S_DN;
            end else begin
               st_in = S_RSP;
            end
         end
         S_RSP: begin
            rsp_in = '{popped_key: 32'(pop_ff), status: stat_ff,
                       front_key: (cnt_ff != '0) ? 32'(root_ff) : 32'd0,
                       count: 11'(cnt_ff)};
            rv_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      root_in = (we && wa == '0) ? wd : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
      pos_ff <= pos_in; val_ff <= val_in; lk_ff <= lk_in; root_ff <= root_in;
      pop_ff <= pop_in; stat_ff <= stat_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ----- src/binary_min_heap_queue_top.sv -----
// Top level: binary min-heap priority queue; front request queue plus heap sequencer.
// Depends on bmhq_pkg, bmhq_front, bmhq_back.
//  channel | direction | handshake
//  req     | in        | req_push / req_full, req_data
//  rsp     | out       | rsp_pop / rsp_empty, rsp_data
// A request is registered in the two-entry queue before the sequencer sees it. A push then
// climbs, reading one parent per level; a pop moves the last entry to the root and descends,
// reading each child per level; refused requests go straight to the result.
// Synchronous reset empties the heap; RAM contents are not cleared.
// The sequencer starts no request while its result waits; the two-entry queue keeps accepting until full.
`default_nettype none
module binary_min_heap_queue_top import bmhq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   bmhq_front u_front (.clock, .reset, .req_push, .req_full, .req_data,
                       .cmd_valid, .cmd_data, .cmd_take);
   bmhq_back  u_back  (.clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
                       .rsp_empty, .rsp_pop, .rsp_data);

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.count <= 11'(CAPACITY))
      else $error("count over capacity");
   a_front0: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.count == '0) |-> rsp_data.front_key == '0)
      else $error("front key on empty heap");
`endif
endmodule
`default_nettype wire

// ----- bench/heap_checker.sv -----
// Checker for the binary min-heap queue: watches both channels, predicts each result.
// Depends on bmhq_pkg; instantiated by tb_top beside the block.
`default_nettype none
module heap_checker import bmhq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire logic    req_full,
   input  wire req_type req_data,
   input  wire logic    rsp_empty,
   input  wire logic    rsp_pop,
   input  wire rsp_type rsp_data,
   output int           failures,
   output int           pending
);
   logic [KEY_WIDTH-1:0] heap_mem [1:CAPACITY];
   int unsigned          held;
   rsp_type              due_q [$];

   function automatic rsp_type heap_apply(req_type r);
      rsp_type              res;
      int unsigned          pos;
      int unsigned          up;
      int unsigned          lt;
      int unsigned          pick;
      logic [KEY_WIDTH-1:0] val;
      res = '0;
      res.status = ST_OK;
      if (r.kind == KIND_PUSH) begin
         if (held >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            held++;
            pos = held;
            val = r.key[KEY_WIDTH-1:0];
            while (pos > 1) begin
               up = pos >> 1;
               if (val < heap_mem[up]) begin
                  heap_mem[pos] = heap_mem[up];
                  pos = up;
               end else begin
                  break;
               end
            end
            heap_mem[pos] = val;
         end
      end else begin
         if (held == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.popped_key = heap_mem[1];
            val = heap_mem[held];
            held--;
            if (held > 0) begin
               pos = 1;
               forever begin
                  lt = 2 * pos;
                  if (lt > held) break;
                  pick = lt;
                  if (lt + 1 <= held && !(heap_mem[lt] < heap_mem[lt+1])) pick = lt + 1;
                  if (val > heap_mem[pick]) begin
                     heap_mem[pos] = heap_mem[pick];
                     pos = pick;
                  end else begin
                     break;
                  end
               end
               heap_mem[pos] = val;
            end
         end
      end
      res.front_key = (held > 0) ? heap_mem[1] : '0;
      res.count     = held[10:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held     = 0;
         failures <= 0;
         due_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_q.size() == 0) begin
               if (failures < 10)
                  $display("unexpected response %h", rsp_data);
               failures <= failures + 1;
            end else begin
               want = due_q.pop_front();
               if (want !== rsp_data) begin
                  if (failures < 10)
                     $display("mismatch: exp popped=%h st=%0d front=%h cnt=%0d",
                              want.popped_key, want.status, want.front_key, want.count,
                              ", got popped=%h st=%0d front=%h cnt=%0d",
                              rsp_data.popped_key, rsp_data.status, rsp_data.front_key,
                              rsp_data.count);
                  failures <= failures + 1;
               end
            end
         end
         if (req_push && !req_full)
            due_q.push_back(heap_apply(req_data));
      end
      pending <= due_q.size();
   end
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench top for the binary min-heap queue: clock, reset, request stimulus, verdict.
// Depends on bmhq_pkg, binary_min_heap_queue_top and heap_checker.
`default_nettype none
module tb_top;
   import bmhq_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_push = 0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycles = 0;
   bit      no_gaps = 0;

   binary_min_heap_queue_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   heap_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("[binary_min_heap_queue_top] ERROR");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return 32'hFFFF_FFF8 + $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic kind, logic [31:0] key);
      int  gap;
      bit  took;
      gap = idle_len();
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(negedge clock);
      end
      req_push      <= 1;
      req_data.kind <= kind;
      req_data.key  <= key;
      do begin
         @(posedge clock);
         took = !req_full;
         @(negedge clock);
      end while (!took);
   endtask

   task automatic wait_drained();
      req_push <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // result side: random pop gaps, pop held high through back-to-back accepts
   initial begin
      int  gap;
      bit  took;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = idle_len();
         if (gap > 0) begin
            rsp_pop <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1;
         do begin
            @(posedge clock);
            took = !rsp_empty;
            @(negedge clock);
         end while (!took);
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty pop, key extremes, ties, full bit patterns
      send(KIND_POP, 32'hFFFF_FFFF);
      send(KIND_PUSH, 32'hFFFF_FFFF);
      send(KIND_PUSH, 32'h0000_0000);
      send(KIND_PUSH, 32'h0000_0000);
      send(KIND_PUSH, 32'h0000_0005);
      send(KIND_PUSH, 32'h0000_0005);
      send(KIND_PUSH, 32'h0000_0005);
      send(KIND_PUSH, 32'hAAAA_AAAA);
      send(KIND_PUSH, 32'h5555_5555);
      send(KIND_PUSH, 32'h8000_0000);
      send(KIND_PUSH, 32'h0000_0001);
      repeat (11) send(KIND_POP, $urandom);
      send(KIND_POP, 32'h0);
      send(KIND_PUSH, 32'h7FFF_FFFF);
      send(KIND_POP, 32'h0);

      // random mix around small sizes
      for (int i = 0; i < 150; i++) begin
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send(($urandom_range(0, 99) < 55) ? KIND_PUSH : KIND_POP, pick_key());
      end
      no_gaps = 0;
      wait_drained();

      // fill past capacity so pushes get refused
      for (int i = 0; i < 1030; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         send(KIND_PUSH, pick_key());
      end
      repeat (10) send(KIND_PUSH, pick_key());

      // mostly pops from a large heap
      for (int i = 0; i < 170; i++) begin
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         send(($urandom_range(0, 99) < 80) ? KIND_POP : KIND_PUSH, pick_key());
      end
      no_gaps = 0;

      wait_drained();
      repeat (60) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("[binary_min_heap_queue_top] OK");
      end else begin
         $display("[binary_min_heap_queue_top] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/bmhq_front.sv
src/bmhq_back.sv
src/binary_min_heap_queue_top.sv
bench/heap_checker.sv
bench/tb_top.sv
